[hw/rtl/gffrc_pkg.sv]
// Package for the grid flood fill block: sizes, request codes, register map.
// No dependencies.
`default_nettype none
package gffrc_pkg;
  localparam int unsigned MaxRows   = 64;
  localparam int unsigned MaxCols   = 64;
  localparam int unsigned ColorBits = 8;
  localparam int unsigned RowBits   = $clog2(MaxRows);
  localparam int unsigned ColBits   = $clog2(MaxCols);
  localparam int unsigned Cells     = MaxRows * MaxCols;
  localparam int unsigned IdxBits   = RowBits + ColBits;
  localparam int unsigned TopBits   = IdxBits + 1;
  localparam int unsigned CntBits   = 13;

  typedef logic [1:0] req_type_t;
  localparam req_type_t ReqWrite = 2'd0;
  localparam req_type_t ReqRead  = 2'd1;
  localparam req_type_t ReqFill  = 2'd2;

  localparam logic [2:0] RegRows = 3'd0;
  localparam logic [2:0] RegCols = 3'd4;
endpackage
`default_nettype wire

[hw/rtl/gffrc_ram.sv]
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module gffrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/grid_flood_fill_recolor_count.sv]
// Grid flood fill top level: request/result channels, APB registers, fill sequencer.
// Depends on gffrc_pkg and gffrc_ram.
//
// A fill runs a clear sweep over the visited memory (one entry a cycle), then, if
// the new color differs from the old one, a paint walk and a second clear, and
// then a count walk. Each walk pops a cell through the pop, pop-wait and cell
// states and probes each neighbor through the probe, probe-wait and check states
// over the shared color memory port. The block accepts one request at a time.
`default_nettype none
module grid_flood_fill_recolor_count (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [5:0]  row_i,
  input  wire logic [5:0]  col_i,
  input  wire logic [7:0]  color_i,
  output logic             rsp_valid_o,
  input  wire logic        rsp_ready_i,
  output logic [7:0]       read_color_o,
  output logic [12:0]      fill_count_o,
  output logic             status_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gffrc_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRdOld = 4'd1;
  localparam logic [3:0] StClear = 4'd2;
  localparam logic [3:0] StPush0 = 4'd3;
  localparam logic [3:0] StPop   = 4'd4;
  localparam logic [3:0] StPopW  = 4'd5;
  localparam logic [3:0] StCell  = 4'd6;
  localparam logic [3:0] StProbe = 4'd7;
  localparam logic [3:0] StPrbW  = 4'd8;
  localparam logic [3:0] StCheck = 4'd9;
  localparam logic [3:0] StResp  = 4'd10;
  localparam logic [3:0] StRdW   = 4'd11;

  logic [6:0] rows_q, cols_q;
  logic [3:0] st_q, st_d;
  logic [IdxBits-1:0] start_q, cur_q, nb_q, clr_q;
  logic [ColorBits-1:0] newc_q, match_q;
  logic paint_q;
  logic [1:0] dir_q;
  logic [TopBits-1:0] top_q;
  logic rsp_v_q;
  logic [7:0] rd_q;
  logic st_bit_q;

  logic c_we, v_we, p_we, v_wd;
  logic [IdxBits-1:0] c_wa, c_ra, v_wa, v_ra, p_wa, p_ra, p_wd;
  logic [ColorBits-1:0] c_wd, c_rd;
  logic v_rd;
  logic [IdxBits-1:0] p_rd;

  gffrc_ram #(.Width(ColorBits), .Depth(Cells)) u_color (.clk_i, .we_i(c_we),
    .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));
  gffrc_ram #(.Width(1), .Depth(Cells)) u_visit (.clk_i, .we_i(v_we),
    .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(v_ra), .rdata_o(v_rd));
  gffrc_ram #(.Width(IdxBits), .Depth(Cells)) u_stack (.clk_i, .we_i(p_we),
    .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));

  logic [6:0] nr, nc;
  assign nr = (rows_q > 7'(MaxRows)) ? 7'(MaxRows) : rows_q;
  assign nc = (cols_q > 7'(MaxCols)) ? 7'(MaxCols) : cols_q;

  logic in_grid;
  assign in_grid = ({1'b0, row_i} < nr) && ({1'b0, col_i} < nc);

  logic [RowBits-1:0] cr;
  logic [ColBits-1:0] cc;
  assign cr = cur_q[IdxBits-1:ColBits];
  assign cc = cur_q[ColBits-1:0];

  logic nb_ok;
  logic [IdxBits-1:0] nb_idx;
  always_comb begin
    nb_ok  = 1'b0;
    nb_idx = cur_q;
    case (dir_q)
      2'd0: begin
        nb_ok  = (cr != '0);
        nb_idx = {cr - 1'b1, cc};
      end
      2'd1: begin
        nb_ok  = ({1'b0, cc} + 7'd1 < nc);
        nb_idx = {cr, cc + 1'b1};
      end
      2'd2: begin
        nb_ok  = ({1'b0, cr} + 7'd1 < nr);
        nb_idx = {cr + 1'b1, cc};
      end
      default: begin
        nb_ok  = (cc != '0);
        nb_idx = {cr, cc - 1'b1};
      end
    endcase
  end

  logic req_acc;
  assign req_ready_o = (st_q == StIdle) && !rsp_v_q;
  assign req_acc     = req_valid_i && req_ready_o;

  always_comb begin
    st_d = st_q;
    c_we = 1'b0; c_wa = cur_q; c_wd = newc_q; c_ra = nb_q;
    v_we = 1'b0; v_wa = clr_q; v_wd = 1'b0; v_ra = nb_q;
    p_we = 1'b0; p_wa = top_q[IdxBits-1:0]; p_wd = nb_q;
    p_ra = top_q[IdxBits-1:0] - 1'b1;
    case (st_q)
      StIdle: begin
        c_ra = {row_i, col_i};
        if (req_acc) begin
          if (req_type_i <= ReqFill && !in_grid) st_d = StResp;
          else if (req_type_i == ReqWrite) begin
            c_we = 1'b1; c_wa = {row_i, col_i}; c_wd = color_i[ColorBits-1:0];
            st_d = StResp;
          end else if (req_type_i == ReqRead) st_d = StRdW;
          else if (req_type_i == ReqFill) st_d = StRdOld;
          else st_d = StResp;
        end
      end
      StRdW:  st_d = StResp;
      StRdOld: st_d = StClear;
      StClear: begin
        v_we = 1'b1;
        if (clr_q == IdxBits'(Cells - 1)) st_d = StPush0;
      end
      StPush0: begin
        v_we = 1'b1; v_wa = start_q; v_wd = 1'b1;
        p_we = 1'b1; p_wa = '0; p_wd = start_q;
        st_d = StPop;
      end
      StPop: begin
        if (top_q == '0) begin
          st_d = paint_q ? StClear : StResp;
        end else st_d = StPopW;
      end
      StPopW: st_d = StCell;
      StCell: st_d = StProbe;
      StProbe: begin
        if (paint_q) begin
          c_we = 1'b1;
        end
        if (nb_ok) st_d = StPrbW;
        else if (dir_q == 2'd3) st_d = StPop;
      end
      StPrbW: st_d = StCheck;
      StCheck: begin
        if (!v_rd && c_rd == match_q) begin
          v_we = 1'b1; v_wa = nb_q; v_wd = 1'b1;
          p_we = 1'b1;
        end
        st_d = (dir_q == 2'd3) ? StPop : StProbe;
      end
      StResp: if (rsp_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
    if (st_q == StResp && rsp_v_q && !rsp_ready_i) st_d = StResp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      rows_q  <= 7'd64;
      cols_q  <= 7'd64;
      top_q   <= '0;
      rsp_v_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      st_q <= st_d;
      if (psel && penable && pwrite) begin
        if (paddr == RegRows) rows_q <= pwdata[6:0];
        if (paddr == RegCols) cols_q <= pwdata[6:0];
      end
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
      if (st_q == StPush0) top_q <= TopBits'(1);
      if (st_q == StPop && top_q != '0) top_q <= top_q - 1'b1;
      if (p_we && st_q == StCheck) top_q <= top_q + 1'b1;
      if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
      else if (st_d == StResp && st_q != StResp) rsp_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      start_q  <= {row_i, col_i};
      cur_q    <= {row_i, col_i};
      newc_q   <= color_i[ColorBits-1:0];
      rd_q     <= '0;
      st_bit_q <= (req_type_i <= ReqFill) && !in_grid;
    end
    if (st_q == StRdW) rd_q <= 8'(c_rd);
    if (st_q == StRdOld) begin
      paint_q <= (c_rd != newc_q);
      match_q <= c_rd;
    end
    if (st_q == StPop && top_q == '0 && paint_q) begin
      paint_q <= 1'b0;
      match_q <= newc_q;
    end
    if (st_q == StPopW) begin
      cur_q <= p_rd;
      dir_q <= 2'd0;
    end
    if (st_q == StProbe) begin
      nb_q <= nb_idx;
      if (!nb_ok) dir_q <= dir_q + 1'b1;
    end
    if (st_q == StCheck) dir_q <= dir_q + 1'b1;
  end

  logic [CntBits-1:0] res_cnt_q;
  always_ff @(posedge clk_i) begin
    if (req_acc) res_cnt_q <= '0;
    if (st_q == StPopW && !paint_q && res_cnt_q != '1) res_cnt_q <= res_cnt_q + 1'b1;
    if (st_q == StClear && clr_q == '0) res_cnt_q <= '0;
  end

  assign rsp_valid_o  = rsp_v_q;
  assign read_color_o = rd_q;
  assign fill_count_o = res_cnt_q;
  assign status_o     = st_bit_q;
  assign pready       = 1'b1;
  assign prdata       = (paddr == RegRows) ? {25'd0, rows_q} :
                        (paddr == RegCols) ? {25'd0, cols_q} : 32'd0;

`ifndef ASSERT_OFF
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TopBits'(Cells)) else $error("stack overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> !rsp_v_q) else $error("ready with pending result");
  a_rsp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q |-> st_q == StResp || st_q == StIdle) else $error("result outside response");
`endif
endmodule
`default_nettype wire

[verif/tb_top.sv]
// Testbench for grid_flood_fill_recolor_count: writes, reads, fills and APB sizing.
// Predicts each result with its own grid copy and flood walk; depends on gffrc_pkg.
`timescale 1ns / 1ps
module tb_top;
  import gffrc_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] color;
    bit         hold;
  } request_t;

  typedef struct packed {
    logic [7:0]  read_color;
    logic [12:0] fill_count;
    logic        status;
  } result_t;

  localparam req_type_t ReqNone = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic [1:0] req_type_i = '0;
  logic [5:0] row_i = '0;
  logic [5:0] col_i = '0;
  logic [7:0] color_i = '0;
  logic rsp_ready_i = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic req_ready_o, rsp_valid_o, status_o, pready;
  logic [7:0] read_color_o;
  logic [12:0] fill_count_o;
  logic [31:0] prdata;

  grid_flood_fill_recolor_count i_dut (.*);

  always #6 clk_i = ~clk_i;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  logic [7:0] grid_colors[Cells];
  logic [6:0] rows_reg = 7'd64, cols_reg = 7'd64;
  int unsigned mismatches = 0, sent = 0, received = 0, fills = 0, cycles = 0;
  int unsigned send_gap = 0, stall_left = 0;
  bit burst = 0;

  function automatic int unsigned used_rows();
    return (rows_reg > MaxRows) ? MaxRows : rows_reg;
  endfunction

  function automatic int unsigned used_cols();
    return (cols_reg > MaxCols) ? MaxCols : cols_reg;
  endfunction

  function automatic int unsigned flood_region(int r0, int c0, logic [7:0] match, bit paint,
                                               logic [7:0] newc);
    bit seen[Cells];
    int stack[$];
    int dr[4] = '{-1, 0, 1, 0};
    int dc[4] = '{0, 1, 0, -1};
    int idx, r, c, rr, cc, n;
    int unsigned popped = 0;
    seen[r0 * MaxCols + c0] = 1;
    stack.push_back(r0 * MaxCols + c0);
    while (stack.size() > 0) begin
      idx = stack.pop_back();
      r = idx / MaxCols;
      c = idx % MaxCols;
      popped++;
      if (paint) grid_colors[idx] = newc;
      for (int d = 0; d < 4; d++) begin
        rr = r + dr[d];
        cc = c + dc[d];
        if (rr < 0 || rr >= used_rows() || cc < 0 || cc >= used_cols()) continue;
        n = rr * MaxCols + cc;
        if (seen[n] || grid_colors[n] != match) continue;
        seen[n] = 1;
        stack.push_back(n);
      end
    end
    return popped;
  endfunction

  function automatic result_t predict_result(request_t q);
    result_t res = '0;
    int unsigned idx = q.row * MaxCols + q.col;
    int unsigned cnt;
    logic [7:0] old;
    if (q.kind != ReqNone && !(q.row < used_rows() && q.col < used_cols())) begin
      res.status = 1'b1;
    end else if (q.kind == ReqWrite) begin
      grid_colors[idx] = q.color;
    end else if (q.kind == ReqRead) begin
      res.read_color = grid_colors[idx];
    end else if (q.kind == ReqFill) begin
      old = grid_colors[idx];
      if (old != q.color) void'(flood_region(q.row, q.col, old, 1'b1, q.color));
      cnt = flood_region(q.row, q.col, q.color, 1'b0, '0);
      res.fill_count = (cnt > 8191) ? 13'd8191 : cnt[12:0];
    end
    return res;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire;
    bit next_valid;
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
    end else begin
      fire = req_valid_i && req_ready_o;
      next_valid = req_valid_i && !fire;
      if (fire) begin
        expected_results.push_back(predict_result(
            request_t'{req_type_i, row_i, col_i, color_i, 1'b0}));
        if (req_type_i == ReqFill) fills++;
        sent++;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].hold || expected_results.size() == 0)) begin
          req_type_i <= pending_reqs[0].kind;
          row_i <= pending_reqs[0].row;
          col_i <= pending_reqs[0].col;
          color_i <= pending_reqs[0].color;
          void'(pending_reqs.pop_front());
          next_valid = 1'b1;
          send_gap = burst ? 0 : $urandom_range(0, 10);
        end
      end
      req_valid_i <= next_valid;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) begin
        got = '{read_color_o, fill_count_o, status_o};
        received++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
        stall_left = burst ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) stall_left--;
      rsp_ready_i <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] kind, int r, int c, int color, bit hold = 0);
    pending_reqs.push_back(request_t'{kind, r[5:0], c[5:0], color[7:0], hold});
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_valid_i || expected_results.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [6:0] value);
    wait_idle();
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {25'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegRows) rows_reg = value;
    else rows_reg = rows_reg;
    if (addr == RegCols) cols_reg = value;
  endtask

  task automatic random_phase(int nrows, int ncols, int count);
    int pick, color;
    write_reg(RegRows, nrows[6:0]);
    write_reg(RegCols, ncols[6:0]);
    burst = ($urandom_range(0, 2) == 0);
    for (int r = 0; r < nrows; r++)
      for (int c = 0; c < ncols; c++) push_req(ReqWrite, r, c, $urandom_range(0, 2));
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      color = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
      if (pick < 35)
        push_req(ReqWrite, $urandom_range(0, nrows - 1), $urandom_range(0, ncols - 1), color);
      else if (pick < 55)
        push_req(ReqRead, $urandom_range(0, nrows - 1), $urandom_range(0, ncols - 1), color);
      else if (pick < 90)
        push_req(ReqFill, $urandom_range(0, nrows - 1), $urandom_range(0, ncols - 1), color,
                 k == count / 2);
      else if (pick < 95)
        push_req(2'($urandom_range(0, 2)), $urandom_range(0, 63), $urandom_range(ncols, 63),
                 color);
      else
        push_req(ReqNone, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full 64x64 grid, cheap corner fills
    push_req(ReqWrite, 0, 0, 5);
    push_req(ReqWrite, 0, 1, 9);
    push_req(ReqWrite, 1, 0, 200);
    push_req(ReqWrite, 63, 63, 255);
    push_req(ReqWrite, 63, 62, 0);
    push_req(ReqWrite, 62, 63, 1);
    push_req(ReqRead, 63, 63, 0);
    push_req(ReqFill, 0, 0, 170);
    push_req(ReqFill, 63, 63, 255, 1);
    push_req(ReqRead, 0, 0, 85);
    push_req(ReqNone, 42, 21, 255);
    push_req(ReqRead, 1, 0, 0);

    // no cells in use
    write_reg(RegRows, 7'd0);
    write_reg(RegCols, 7'd5);
    push_req(ReqWrite, 0, 0, 3);
    push_req(ReqRead, 0, 0, 0);
    push_req(ReqFill, 0, 0, 1);

    // oversized rows clamp to 64, single column
    write_reg(RegRows, 7'd127);
    write_reg(RegCols, 7'd1);
    for (int r = 59; r < 64; r++) push_req(ReqWrite, r, 0, (r < 60) ? 7 : 4);
    push_req(ReqFill, 61, 0, 6);
    push_req(ReqFill, 63, 0, 6);
    push_req(ReqRead, 40, 1, 0);
    push_req(ReqFill, 5, 63, 2);

    random_phase(1, 1, 8);
    random_phase(4, 4, 16);
    random_phase(3, 5, 15);

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests (%0d fills), %0d results, grid sizes 0 to 64 and clamped",
             sent, fills, received);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/gffrc_pkg.sv
hw/rtl/gffrc_ram.sv
hw/rtl/grid_flood_fill_recolor_count.sv
verif/tb_top.sv
